@@ rtl/rwpe_pkg.sv @@
// ----------------------------------------------------------------------------
// rwpe_pkg
// Types and constants shared by the register-write program engine.
// ----------------------------------------------------------------------------
package rwpe_pkg;

    // Operation codes carried on the func field.
    typedef enum logic [1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_ERASE = 2'd1,
        FUNC_EXEC  = 2'd2,
        FUNC_READ  = 2'd3
    } t_func;

    // Configuration register word index (paddr[2]).
    typedef enum logic {
        REG_APPLY_MASK    = 1'b0,
        REG_PROGRAM_MAGIC = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [1:0] apply_mask;
        logic [7:0] program_magic;
    } t_cfg;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD,
        S_LOAD_END,
        S_ERASE,
        S_MAGIC,
        S_CHECK,
        S_RD_OUT,
        S_OP,
        S_OPCODE,
        S_VALUE,
        S_W1,
        S_W2,
        S_FLUSH
    } t_state;

    localparam int unsigned PADDR_W      = 3;
    localparam int unsigned RES_W        = 5;
    localparam logic [RES_W-1:0] MAX_RES = 5'd30;

    localparam logic [8:0] ADDR_A_BASE = 9'h080;
    localparam logic [8:0] ADDR_B_BASE = 9'h180;
    localparam logic [7:0] ERASED_BYTE = 8'hFF;
    localparam logic [7:0] ZERO_BYTE   = 8'h00;

    localparam int unsigned OP_SET_BIT  = 7;
    localparam int unsigned OP_CHB_BIT  = 6;
    localparam int unsigned MASK_A_BIT  = 0;
    localparam int unsigned MASK_B_BIT  = 1;
    localparam int unsigned OFFSET_W    = 6;

endpackage

@@ rtl/rwpe_store.sv @@
// ----------------------------------------------------------------------------
// rwpe_store
// Program byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rwpe_store #(
    parameter int unsigned DEPTH = 224,
    parameter int unsigned AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/rwpe_cfg.sv @@
// ----------------------------------------------------------------------------
// rwpe_cfg
// APB-style configuration registers: apply mask and program magic byte.
// ----------------------------------------------------------------------------
module rwpe_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rwpe_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output rwpe_pkg::t_cfg                o_cfg
);

    rwpe_pkg::t_cfg     r_cfg;
    rwpe_pkg::t_reg_idx reg_idx;
    logic               wr_en;

    assign reg_idx = rwpe_pkg::t_reg_idx'(paddr[2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                rwpe_pkg::REG_APPLY_MASK:    r_cfg.apply_mask    <= pwdata[1:0];
                rwpe_pkg::REG_PROGRAM_MAGIC: r_cfg.program_magic <= pwdata[7:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            rwpe_pkg::REG_APPLY_MASK:    prdata = {30'd0, r_cfg.apply_mask};
            rwpe_pkg::REG_PROGRAM_MAGIC: prdata = {24'd0, r_cfg.program_magic};
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/rwpe_seq.sv @@
// ----------------------------------------------------------------------------
// rwpe_seq
// Sequencer: drives the store one access per cycle, walks programs, holds one
// pending write so the final beat can be flagged, and owns the output register.
// ----------------------------------------------------------------------------
module rwpe_seq #(
    parameter int unsigned SLOT_COUNT = 7,
    parameter int unsigned SLOT_BYTES = 32,
    parameter int unsigned DEPTH      = 224,
    parameter int unsigned AW         = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rwpe_pkg::t_cfg  i_cfg,
    // input channel
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [1:0]      i_func,
    input  logic [2:0]      i_slot,
    input  logic [4:0]      i_byte_index,
    input  logic [7:0]      i_write_data,
    // output channel
    output logic            o_valid,
    input  logic            i_ready,
    output logic [8:0]      o_reg_address,
    output logic [7:0]      o_reg_value,
    output logic            o_write_valid,
    output logic [7:0]      o_read_data,
    output logic            o_slot_valid,
    output logic            o_last,
    // store port
    output logic            o_mem_we,
    output logic [AW-1:0]   o_mem_waddr,
    output logic [7:0]      o_mem_wdata,
    output logic            o_mem_re,
    output logic [AW-1:0]   o_mem_raddr,
    input  logic [7:0]      i_mem_rdata
);

    localparam int unsigned PW = $clog2(SLOT_BYTES + 1);

    rwpe_pkg::t_state r_state, n_state;
    rwpe_pkg::t_func  r_func,  n_func;
    logic [AW-1:0]    r_base,  n_base;
    logic [4:0]       r_idx,   n_idx;
    logic [7:0]       r_data,  n_data;
    logic [AW-1:0]    r_cnt,   n_cnt;
    logic [PW-1:0]    r_pos,   n_pos;
    logic [rwpe_pkg::RES_W-1:0] r_nres, n_nres;
    logic [7:0]       r_op,    n_op;
    logic [7:0]       r_val,   n_val;
    logic             r_slot_ok, n_slot_ok;
    logic             r_pend_vld, n_pend_vld;
    logic [8:0]       r_pend_addr, n_pend_addr;
    logic [7:0]       r_pend_val,  n_pend_val;
    logic             r_out_vld,  n_out_vld;
    logic [8:0]       r_out_addr, n_out_addr;
    logic [7:0]       r_out_value, n_out_value;
    logic             r_out_wv,   n_out_wv;
    logic [7:0]       r_out_rd,   n_out_rd;
    logic             r_out_sv,   n_out_sv;
    logic             r_out_last, n_out_last;

    logic             in_slot_ok;
    logic             idx_ok;
    logic             out_free;
    logic             can_push;
    logic             more_pairs;
    logic             res_room;
    logic             cand1_vld;
    logic [8:0]       cand1_addr;
    logic [8:0]       chb_addr;
    logic             need2;
    logic [PW-1:0]    pos_step;

    assign in_slot_ok = {29'd0, i_slot} < SLOT_COUNT;
    assign idx_ok     = {27'd0, r_idx} < SLOT_BYTES;
    assign out_free   = !r_out_vld || i_ready;
    assign can_push   = !r_pend_vld || out_free;
    assign more_pairs = (32'(r_pos) + 32'd1) < SLOT_BYTES;
    assign res_room   = r_nres < rwpe_pkg::MAX_RES;
    assign pos_step   = r_pos + PW'(2);

    // Decode of the current instruction (opcode in r_op, value in r_val).
    assign chb_addr   = rwpe_pkg::ADDR_B_BASE
                      + {3'd0, r_op[rwpe_pkg::OFFSET_W-1:0]};
    assign cand1_vld  = r_op[rwpe_pkg::OP_CHB_BIT]
                      || i_cfg.apply_mask[rwpe_pkg::MASK_A_BIT]
                      || i_cfg.apply_mask[rwpe_pkg::MASK_B_BIT];
    assign cand1_addr = (!r_op[rwpe_pkg::OP_CHB_BIT]
                         && i_cfg.apply_mask[rwpe_pkg::MASK_A_BIT])
                      ? rwpe_pkg::ADDR_A_BASE + {3'd0, r_op[rwpe_pkg::OFFSET_W-1:0]}
                      : chb_addr;
    assign need2      = !r_op[rwpe_pkg::OP_CHB_BIT]
                      && i_cfg.apply_mask[rwpe_pkg::MASK_A_BIT]
                      && i_cfg.apply_mask[rwpe_pkg::MASK_B_BIT];

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rwpe_pkg::S_CLEAR: begin
                if (r_cnt == AW'(DEPTH - 1)) n_state = rwpe_pkg::S_IDLE;
            end
            rwpe_pkg::S_IDLE: begin
                if (i_valid && in_slot_ok) begin
                    unique case (rwpe_pkg::t_func'(i_func))
                        rwpe_pkg::FUNC_LOAD:  n_state = rwpe_pkg::S_LOAD;
                        rwpe_pkg::FUNC_ERASE: n_state = rwpe_pkg::S_ERASE;
                        rwpe_pkg::FUNC_EXEC,
                        rwpe_pkg::FUNC_READ:  n_state = rwpe_pkg::S_MAGIC;
                    endcase
                end
            end
            rwpe_pkg::S_LOAD:     n_state = rwpe_pkg::S_LOAD_END;
            rwpe_pkg::S_LOAD_END: n_state = rwpe_pkg::S_IDLE;
            rwpe_pkg::S_ERASE: begin
                if (r_cnt == AW'(SLOT_BYTES - 1)) n_state = rwpe_pkg::S_IDLE;
            end
            rwpe_pkg::S_MAGIC: n_state = rwpe_pkg::S_CHECK;
            rwpe_pkg::S_CHECK: begin
                if (r_func == rwpe_pkg::FUNC_READ) begin
                    n_state = rwpe_pkg::S_RD_OUT;
                end else if (i_mem_rdata == i_cfg.program_magic) begin
                    n_state = rwpe_pkg::S_OP;
                end else begin
                    n_state = rwpe_pkg::S_IDLE;
                end
            end
            rwpe_pkg::S_RD_OUT: begin
                if (out_free) n_state = rwpe_pkg::S_IDLE;
            end
            rwpe_pkg::S_OP: begin
                n_state = (more_pairs && res_room) ? rwpe_pkg::S_OPCODE
                                                   : rwpe_pkg::S_FLUSH;
            end
            rwpe_pkg::S_OPCODE: begin
                n_state = i_mem_rdata[rwpe_pkg::OP_SET_BIT] ? rwpe_pkg::S_VALUE
                                                            : rwpe_pkg::S_FLUSH;
            end
            rwpe_pkg::S_VALUE: n_state = rwpe_pkg::S_W1;
            rwpe_pkg::S_W1: begin
                if (!cand1_vld) begin
                    n_state = rwpe_pkg::S_OP;
                end else if (can_push) begin
                    n_state = need2 ? rwpe_pkg::S_W2 : rwpe_pkg::S_OP;
                end
            end
            rwpe_pkg::S_W2: begin
                if (!res_room || can_push) n_state = rwpe_pkg::S_OP;
            end
            rwpe_pkg::S_FLUSH: begin
                if (!r_pend_vld || out_free) n_state = rwpe_pkg::S_IDLE;
            end
            default: n_state = rwpe_pkg::S_IDLE;
        endcase
    end

    // ---------------- datapath and store controls ----------------
    always_comb begin
        n_func      = r_func;
        n_base      = r_base;
        n_idx       = r_idx;
        n_data      = r_data;
        n_cnt       = r_cnt;
        n_pos       = r_pos;
        n_nres      = r_nres;
        n_op        = r_op;
        n_val       = r_val;
        n_slot_ok   = r_slot_ok;
        n_pend_vld  = r_pend_vld;
        n_pend_addr = r_pend_addr;
        n_pend_val  = r_pend_val;
        n_out_vld   = r_out_vld && !i_ready;
        n_out_addr  = r_out_addr;
        n_out_value = r_out_value;
        n_out_wv    = r_out_wv;
        n_out_rd    = r_out_rd;
        n_out_sv    = r_out_sv;
        n_out_last  = r_out_last;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_base + r_cnt;
        o_mem_wdata = rwpe_pkg::ERASED_BYTE;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_base;
        o_ready     = 1'b0;

        unique case (r_state)
            rwpe_pkg::S_CLEAR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_cnt;
                n_cnt       = r_cnt + AW'(1);
            end
            rwpe_pkg::S_IDLE: begin
                o_ready = 1'b1;
                n_func  = rwpe_pkg::t_func'(i_func);
                n_base  = AW'(i_slot) * AW'(SLOT_BYTES);
                n_idx   = i_byte_index;
                n_data  = i_write_data;
                n_cnt   = '0;
                n_nres  = '0;
            end
            rwpe_pkg::S_LOAD: begin
                o_mem_we    = idx_ok;
                o_mem_waddr = r_base + AW'(r_idx);
                o_mem_wdata = r_data;
            end
            rwpe_pkg::S_LOAD_END: begin
                // last byte of the slot is always the terminator
                o_mem_we    = 1'b1;
                o_mem_waddr = r_base + AW'(SLOT_BYTES - 1);
                o_mem_wdata = rwpe_pkg::ZERO_BYTE;
            end
            rwpe_pkg::S_ERASE: begin
                o_mem_we = 1'b1;
                n_cnt    = r_cnt + AW'(1);
            end
            rwpe_pkg::S_MAGIC: begin
                o_mem_re    = 1'b1;
                o_mem_raddr = r_base;
            end
            rwpe_pkg::S_CHECK: begin
                n_slot_ok   = (i_mem_rdata == i_cfg.program_magic);
                n_pos       = PW'(1);
                o_mem_re    = (r_func == rwpe_pkg::FUNC_READ) && idx_ok;
                o_mem_raddr = r_base + AW'(r_idx);
            end
            rwpe_pkg::S_RD_OUT: begin
                if (out_free) begin
                    n_out_vld   = 1'b1;
                    n_out_addr  = '0;
                    n_out_value = '0;
                    n_out_wv    = 1'b0;
                    n_out_rd    = idx_ok ? i_mem_rdata : rwpe_pkg::ZERO_BYTE;
                    n_out_sv    = r_slot_ok;
                    n_out_last  = 1'b1;
                end
            end
            rwpe_pkg::S_OP: begin
                o_mem_re    = more_pairs && res_room;
                o_mem_raddr = r_base + AW'(r_pos);
            end
            rwpe_pkg::S_OPCODE: begin
                n_op        = i_mem_rdata;
                o_mem_re    = 1'b1;
                o_mem_raddr = r_base + AW'(r_pos) + AW'(1);
            end
            rwpe_pkg::S_VALUE: begin
                n_val = i_mem_rdata;
            end
            rwpe_pkg::S_W1: begin
                if (!cand1_vld) begin
                    n_pos = pos_step;
                end else if (can_push) begin
                    // previous write is not the last one: release it
                    if (r_pend_vld) begin
                        n_out_vld   = 1'b1;
                        n_out_addr  = r_pend_addr;
                        n_out_value = r_pend_val;
                        n_out_wv    = 1'b1;
                        n_out_rd    = '0;
                        n_out_sv    = 1'b1;
                        n_out_last  = 1'b0;
                    end
                    n_pend_vld  = 1'b1;
                    n_pend_addr = cand1_addr;
                    n_pend_val  = r_val;
                    n_nres      = r_nres + rwpe_pkg::RES_W'(1);
                    if (!need2) n_pos = pos_step;
                end
            end
            rwpe_pkg::S_W2: begin
                if (!res_room) begin
                    n_pos = pos_step;
                end else if (can_push) begin
                    if (r_pend_vld) begin
                        n_out_vld   = 1'b1;
                        n_out_addr  = r_pend_addr;
                        n_out_value = r_pend_val;
                        n_out_wv    = 1'b1;
                        n_out_rd    = '0;
                        n_out_sv    = 1'b1;
                        n_out_last  = 1'b0;
                    end
                    n_pend_vld  = 1'b1;
                    n_pend_addr = chb_addr;
                    n_pend_val  = r_val;
                    n_nres      = r_nres + rwpe_pkg::RES_W'(1);
                    n_pos       = pos_step;
                end
            end
            rwpe_pkg::S_FLUSH: begin
                if (r_pend_vld && out_free) begin
                    n_out_vld   = 1'b1;
                    n_out_addr  = r_pend_addr;
                    n_out_value = r_pend_val;
                    n_out_wv    = 1'b1;
                    n_out_rd    = '0;
                    n_out_sv    = 1'b1;
                    n_out_last  = 1'b1;
                    n_pend_vld  = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= rwpe_pkg::S_CLEAR;
            r_cnt      <= '0;
            r_nres     <= '0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_nres     <= n_nres;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func      <= n_func;
        r_base      <= n_base;
        r_idx       <= n_idx;
        r_data      <= n_data;
        r_pos       <= n_pos;
        r_op        <= n_op;
        r_val       <= n_val;
        r_slot_ok   <= n_slot_ok;
        r_pend_addr <= n_pend_addr;
        r_pend_val  <= n_pend_val;
        r_out_addr  <= n_out_addr;
        r_out_value <= n_out_value;
        r_out_wv    <= n_out_wv;
        r_out_rd    <= n_out_rd;
        r_out_sv    <= n_out_sv;
        r_out_last  <= n_out_last;
    end

    assign o_valid       = r_out_vld;
    assign o_reg_address = r_out_addr;
    assign o_reg_value   = r_out_value;
    assign o_write_valid = r_out_wv;
    assign o_read_data   = r_out_rd;
    assign o_slot_valid  = r_out_sv;
    assign o_last        = r_out_last;

endmodule

@@ rtl/register_write_program_engine.sv @@
// ----------------------------------------------------------------------------
// register_write_program_engine
// Program slot store with load, erase, read and execute of register writes.
//
// Input channel (i_valid/o_ready): one beat carries func, slot, byte_index
// and write_data. Output channel (o_valid/i_ready): one beat per result, with
// o_last marking the final beat of an item. Beats for an unused slot number,
// loads and erases produce no output beat.
// Items make at most one store access per cycle. An execute ends after the
//   magic check when byte 0 is not the magic, else it walks the slot until a
//   stop opcode, the end of the slot or the result cap; output stalls lengthen
//   any item that gives beats. The slot walk sets the worst case.
// The block takes one item at a time; o_ready is low while an item runs.
// After reset the store is swept to 0xFF, one byte a cycle, over all
// SLOT_COUNT * SLOT_BYTES bytes with o_ready low; APB writes work meanwhile.
// A stalled receiver holds the result in the output register; the walk
// keeps one write in hand and waits until the register frees up. A new item
// is accepted while the last result still waits.
// ----------------------------------------------------------------------------
module register_write_program_engine #(
    parameter int unsigned SLOT_COUNT = 7,
    parameter int unsigned SLOT_BYTES = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rwpe_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // input channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_func,
    input  logic [2:0]                    i_slot,
    input  logic [4:0]                    i_byte_index,
    input  logic [7:0]                    i_write_data,
    // output channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [8:0]                    o_reg_address,
    output logic [7:0]                    o_reg_value,
    output logic                          o_write_valid,
    output logic [7:0]                    o_read_data,
    output logic                          o_slot_valid,
    output logic                          o_last
);

    localparam int unsigned DEPTH = SLOT_COUNT * SLOT_BYTES;
    localparam int unsigned AW    = $clog2(DEPTH);

    rwpe_pkg::t_cfg cfg;
    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    logic [7:0]     mem_wdata;
    logic           mem_re;
    logic [AW-1:0]  mem_raddr;
    logic [7:0]     mem_rdata;

    rwpe_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rwpe_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    rwpe_seq #(
        .SLOT_COUNT (SLOT_COUNT),
        .SLOT_BYTES (SLOT_BYTES),
        .DEPTH      (DEPTH),
        .AW         (AW)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_func        (i_func),
        .i_slot        (i_slot),
        .i_byte_index  (i_byte_index),
        .i_write_data  (i_write_data),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_reg_address (o_reg_address),
        .o_reg_value   (o_reg_value),
        .o_write_valid (o_write_valid),
        .o_read_data   (o_read_data),
        .o_slot_valid  (o_slot_valid),
        .o_last        (o_last),
        .o_mem_we      (mem_we),
        .o_mem_waddr   (mem_waddr),
        .o_mem_wdata   (mem_wdata),
        .o_mem_re      (mem_re),
        .o_mem_raddr   (mem_raddr),
        .i_mem_rdata   (mem_rdata)
    );

    // Write beats never carry read data and always report a valid slot.
    a_write_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_write_valid) |-> (o_read_data == 8'd0 && o_slot_valid))
        else $error("write beat carries read data or invalid slot flag");

    // A read beat is the only beat of its item.
    a_read_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_write_valid) |-> (o_last && o_reg_address == 9'd0))
        else $error("read beat not flagged last");

    // An accepted item for a real slot takes the block busy.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && ({29'd0, i_slot} < SLOT_COUNT)) |=> !o_ready)
        else $error("ready stayed high after accepting an item");

    // The clearing sweep follows reset.
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_ready)
        else $error("ready high during store clear");

endmodule

@@ tb/rwpe_beat_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rwpe_beat_checker
// Snoops the configuration port and both channels of the program engine. It
// keeps its own copy of the slot store and registers, works out the beats
// due for each accepted item and compares every output beat against the
// oldest one still due.
// ----------------------------------------------------------------------------
module rwpe_beat_checker
    import rwpe_pkg::*;
#(
    parameter int unsigned SLOT_COUNT = 7,
    parameter int unsigned SLOT_BYTES = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration port
    input  logic                i_psel,
    input  logic                i_penable,
    input  logic                i_pwrite,
    input  logic                i_pready,
    input  logic [PADDR_W-1:0]  i_paddr,
    input  logic [31:0]         i_pwdata,
    // input channel
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic [1:0]          i_in_func,
    input  logic [2:0]          i_in_slot,
    input  logic [4:0]          i_in_byte_index,
    input  logic [7:0]          i_in_write_data,
    // output channel
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic [8:0]          i_out_reg_address,
    input  logic [7:0]          i_out_reg_value,
    input  logic                i_out_write_valid,
    input  logic [7:0]          i_out_read_data,
    input  logic                i_out_slot_valid,
    input  logic                i_out_last,
    // status
    output int                  o_fail_count,
    output int                  o_pending
);

    typedef struct packed {
        logic [8:0] reg_address;
        logic [7:0] reg_value;
        logic       write_valid;
        logic [7:0] read_data;
        logic       slot_valid;
        logic       last;
    } t_engine_beat;

    logic [7:0]   slot_image [SLOT_COUNT*SLOT_BYTES];
    logic [1:0]   apply_mask;
    logic [7:0]   program_magic;
    t_engine_beat due_beats [$];

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        o_fail_count++;
    endtask

    task automatic check_field(input string name, input logic [8:0] got,
                               input logic [8:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
        end
    endtask

    function automatic t_engine_beat write_beat(input logic [8:0] addr,
                                                input logic [7:0] value);
        return '{reg_address: addr, reg_value: value, write_valid: 1'b1,
                 read_data: ZERO_BYTE, slot_valid: 1'b1, last: 1'b0};
    endfunction

    // Apply one item to the store copy and queue up the beats it causes.
    function automatic void predict_engine_beats(input t_func func,
                                                 input logic [2:0] slot,
                                                 input logic [4:0] idx,
                                                 input logic [7:0] data);
        int unsigned           base;
        int unsigned           pos;
        logic [7:0]            op;
        logic [7:0]            value;
        logic [OFFSET_W-1:0]   offset;
        logic                  magic_ok;
        t_engine_beat          beat;
        t_engine_beat          batch [$];

        if (slot >= SLOT_COUNT) begin
            return;
        end
        base = slot * SLOT_BYTES;
        magic_ok = (slot_image[base] == program_magic);

        case (func)
            FUNC_LOAD: begin
                if (idx < SLOT_BYTES) begin
                    slot_image[base + idx] = data;
                end
                slot_image[base + SLOT_BYTES - 1] = ZERO_BYTE;
            end
            FUNC_ERASE: begin
                for (int i = 0; i < SLOT_BYTES; i++) begin
                    slot_image[base + i] = ERASED_BYTE;
                end
            end
            FUNC_READ: begin
                beat = '{reg_address: '0, reg_value: '0, write_valid: 1'b0,
                         read_data: (idx < SLOT_BYTES) ? slot_image[base + idx] : ZERO_BYTE,
                         slot_valid: magic_ok, last: 1'b1};
                due_beats.push_back(beat);
            end
            FUNC_EXEC: begin
                if (!magic_ok) begin
                    return;
                end
                pos = 1;
                while (pos + 1 < SLOT_BYTES && batch.size() < MAX_RES) begin
                    op = slot_image[base + pos];
                    value = slot_image[base + pos + 1];
                    offset = op[OFFSET_W-1:0];
                    if (op == ZERO_BYTE || !op[OP_SET_BIT]) begin
                        break;
                    end
                    if (op[OP_CHB_BIT]) begin
                        batch.push_back(write_beat(ADDR_B_BASE + 9'(offset), value));
                    end else begin
                        if (apply_mask[MASK_A_BIT] && batch.size() < MAX_RES) begin
                            batch.push_back(write_beat(ADDR_A_BASE + 9'(offset), value));
                        end
                        if (apply_mask[MASK_B_BIT] && batch.size() < MAX_RES) begin
                            batch.push_back(write_beat(ADDR_B_BASE + 9'(offset), value));
                        end
                    end
                    pos += 2;
                end
                if (batch.size() > 0) begin
                    beat = batch.pop_back();
                    beat.last = 1'b1;
                    batch.push_back(beat);
                end
                foreach (batch[i]) begin
                    due_beats.push_back(batch[i]);
                end
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_engine_beat want;

        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT * SLOT_BYTES; i++) begin
                slot_image[i] = ERASED_BYTE;
            end
            apply_mask = '0;
            program_magic = ZERO_BYTE;
            due_beats.delete();
            o_fail_count = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[2]))
                    REG_APPLY_MASK:    apply_mask = i_pwdata[1:0];
                    REG_PROGRAM_MAGIC: program_magic = i_pwdata[7:0];
                    default: ;
                endcase
            end
            // output beat first: it always belongs to an older item
            if (i_out_valid && i_out_ready) begin
                if (due_beats.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat addr 0x%0h read 0x%0h",
                                              i_out_reg_address, i_out_read_data));
                end else begin
                    want = due_beats.pop_front();
                    check_field("reg_address", i_out_reg_address, want.reg_address);
                    check_field("reg_value", 9'(i_out_reg_value), 9'(want.reg_value));
                    check_field("write_valid", 9'(i_out_write_valid), 9'(want.write_valid));
                    check_field("read_data", 9'(i_out_read_data), 9'(want.read_data));
                    check_field("slot_valid", 9'(i_out_slot_valid), 9'(want.slot_valid));
                    check_field("last", 9'(i_out_last), 9'(want.last));
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_engine_beats(t_func'(i_in_func), i_in_slot, i_in_byte_index,
                                     i_in_write_data);
            end
        end
        o_pending = due_beats.size();
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the register-write program engine: configuration writes over
// APB, a directed run through the corner cases, an output stall that backs
// up the input, then random programs, reads and noise under several register
// settings and idle patterns. Checking lives in rwpe_beat_checker.
// ----------------------------------------------------------------------------
module tb_top;
    import rwpe_pkg::*;

    localparam int unsigned SLOT_COUNT      = 7;
    localparam int unsigned SLOT_BYTES      = 32;
    localparam int unsigned MAX_PAIRS       = (SLOT_BYTES - 2) / 2;
    localparam int unsigned SETTLE_CYCLES   = 3 * SLOT_BYTES;
    localparam int unsigned PHASES          = 6;
    localparam int unsigned ITEMS_PER_PHASE = 16;
    localparam int unsigned HOLD_CYCLES     = 400;
    localparam logic [7:0]  DIRECTED_MAGIC  = 8'hA5;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    logic                i_valid;
    logic                o_ready;
    logic [1:0]          i_func;
    logic [2:0]          i_slot;
    logic [4:0]          i_byte_index;
    logic [7:0]          i_write_data;
    logic                o_valid;
    logic                i_ready;
    logic [8:0]          o_reg_address;
    logic [7:0]          o_reg_value;
    logic                o_write_valid;
    logic [7:0]          o_read_data;
    logic                o_slot_valid;
    logic                o_last;

    int                  fail_count;
    int                  pending;
    int unsigned         tx_idle_pct;
    int unsigned         rx_idle_pct;
    int unsigned         hold_cycles;
    int unsigned         items_sent;
    logic [7:0]          cur_magic;

    logic [1:0] mask_plan  [PHASES] = '{2'd3, 2'd1, 2'd2, 2'd0, 2'd3, 2'd3};
    logic [7:0] magic_plan [PHASES] = '{DIRECTED_MAGIC, 8'h00, 8'hFF, 8'h3C, 8'hFF, 8'h5A};

    register_write_program_engine #(
        .SLOT_COUNT (SLOT_COUNT),
        .SLOT_BYTES (SLOT_BYTES)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_func        (i_func),
        .i_slot        (i_slot),
        .i_byte_index  (i_byte_index),
        .i_write_data  (i_write_data),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_reg_address (o_reg_address),
        .o_reg_value   (o_reg_value),
        .o_write_valid (o_write_valid),
        .o_read_data   (o_read_data),
        .o_slot_valid  (o_slot_valid),
        .o_last        (o_last)
    );

    rwpe_beat_checker #(
        .SLOT_COUNT (SLOT_COUNT),
        .SLOT_BYTES (SLOT_BYTES)
    ) checker_i (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_psel            (psel),
        .i_penable         (penable),
        .i_pwrite          (pwrite),
        .i_pready          (pready),
        .i_paddr           (paddr),
        .i_pwdata          (pwdata),
        .i_in_valid        (i_valid),
        .i_in_ready        (o_ready),
        .i_in_func         (i_func),
        .i_in_slot         (i_slot),
        .i_in_byte_index   (i_byte_index),
        .i_in_write_data   (i_write_data),
        .i_out_valid       (o_valid),
        .i_out_ready       (i_ready),
        .i_out_reg_address (o_reg_address),
        .i_out_reg_value   (o_reg_value),
        .i_out_write_valid (o_write_valid),
        .i_out_read_data   (o_read_data),
        .i_out_slot_valid  (o_slot_valid),
        .i_out_last        (o_last),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #8_000_000;
        $display("register_write_program_engine test failed");
        $finish;
    end

    // Receiver: random back-pressure, or a counted hold-off when one is asked for.
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                i_ready = 1'b0;
                hold_cycles--;
            end else begin
                i_ready = ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // The APB write and item send tasks end on a falling edge.
    task automatic apb_write(input t_reg_idx idx, input logic [31:0] value);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // Valid is left high after a beat; the next call or a pause decides.
    task automatic send_item(input t_func func, input logic [2:0] slot,
                             input logic [4:0] idx, input logic [7:0] data);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_func = func;
        i_slot = slot;
        i_byte_index = idx;
        i_write_data = data;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        if (slot < SLOT_COUNT) begin
            items_sent++;
        end
    endtask

    task automatic pause_until_drained();
        i_valid = 1'b0;
        wait (pending == 0);
    endtask

    // Loads, erases and executes that write nothing give no beat, so allow for
    // one still running, a full silent slot walk included.
    task automatic apply_setting(input logic [1:0] mask, input logic [7:0] magic);
        pause_until_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        apb_write(REG_APPLY_MASK, 32'(mask));
        apb_write(REG_PROGRAM_MAGIC, 32'(magic));
        cur_magic = magic;
    endtask

    // Magic byte, then (opcode, value) pairs from index 1, maybe a stop opcode.
    task automatic write_program(input logic [2:0] slot, input int unsigned pairs,
                                 input logic plain_only);
        logic [7:0] op;

        send_item(FUNC_LOAD, slot, 5'd0, cur_magic);
        for (int p = 0; p < pairs; p++) begin
            op = 8'($urandom);
            op[OP_SET_BIT] = 1'b1;
            if (plain_only) begin
                op[OP_CHB_BIT] = 1'b0;
            end
            send_item(FUNC_LOAD, slot, 5'(1 + 2 * p), op);
            send_item(FUNC_LOAD, slot, 5'(2 + 2 * p), 8'($urandom));
        end
        if (pairs < MAX_PAIRS && $urandom_range(3) != 0) begin
            op = $urandom_range(1) ? ZERO_BYTE : 8'($urandom_range(8'h7F, 1));
            send_item(FUNC_LOAD, slot, 5'(1 + 2 * pairs), op);
        end
    endtask

    task automatic run_directed();
        // erased store: nothing matches the magic yet
        send_item(FUNC_READ, 3'd0, 5'd0, 8'h00);
        send_item(FUNC_EXEC, 3'd0, 5'd31, 8'hFF);
        // slot number past the end: every operation ignored
        send_item(FUNC_LOAD, 3'd7, 5'd0, DIRECTED_MAGIC);
        send_item(FUNC_READ, 3'd7, 5'd31, 8'h00);
        send_item(FUNC_EXEC, 3'd7, 5'd0, 8'h00);
        send_item(FUNC_ERASE, 3'd7, 5'd0, 8'h00);
        // plain SET at offset 5, channel-B SET at offset 63, plain SET at offset 0,
        // then an opcode with bit 7 clear ends the walk
        send_item(FUNC_LOAD, 3'd0, 5'd0, DIRECTED_MAGIC);
        send_item(FUNC_LOAD, 3'd0, 5'd1, 8'h85);
        send_item(FUNC_LOAD, 3'd0, 5'd2, 8'h00);
        send_item(FUNC_LOAD, 3'd0, 5'd3, 8'hFF);
        send_item(FUNC_LOAD, 3'd0, 5'd5, 8'h80);
        send_item(FUNC_LOAD, 3'd0, 5'd6, 8'h5A);
        send_item(FUNC_LOAD, 3'd0, 5'd7, 8'h7F);
        // last byte is forced back to zero by the load itself
        send_item(FUNC_LOAD, 3'd0, 5'd31, 8'h12);
        send_item(FUNC_EXEC, 3'd0, 5'd0, 8'h00);
        send_item(FUNC_READ, 3'd0, 5'd31, 8'hFF);
        send_item(FUNC_READ, 3'd6, 5'd17, 8'h00);
        // valid program whose first opcode is zero: no beat
        send_item(FUNC_LOAD, 3'd1, 5'd0, DIRECTED_MAGIC);
        send_item(FUNC_LOAD, 3'd1, 5'd1, ZERO_BYTE);
        send_item(FUNC_EXEC, 3'd1, 5'd0, 8'h00);
        send_item(FUNC_ERASE, 3'd0, 5'd9, 8'h33);
        send_item(FUNC_READ, 3'd0, 5'd0, 8'h00);
        send_item(FUNC_READ, 3'd0, 5'd5, 8'h00);
    endtask

    // Full slot of plain SETs with both channels on hits the result cap; the
    // receiver then holds off so the output register fills and input stalls.
    task automatic stall_output();
        write_program(3'd2, MAX_PAIRS, 1'b1);
        hold_cycles = HOLD_CYCLES;
        repeat (3) send_item(FUNC_EXEC, 3'd2, 5'($urandom), 8'($urandom));
        send_item(FUNC_READ, 3'd2, 5'd0, 8'h00);
        pause_until_drained();
    endtask

    task automatic random_step();
        int unsigned pick;
        logic [2:0]  slot;

        pick = $urandom_range(99);
        slot = 3'($urandom_range(SLOT_COUNT - 1));
        if (pick < 50) begin
            if ($urandom_range(3) == 0) begin
                send_item(FUNC_ERASE, slot, 5'($urandom), 8'($urandom));
            end
            write_program(slot, $urandom_range(MAX_PAIRS, 1), $urandom_range(2) == 0);
            send_item(FUNC_EXEC, slot, 5'($urandom), 8'($urandom));
            if ($urandom_range(1)) begin
                send_item(FUNC_READ, slot, 5'($urandom), 8'($urandom));
            end
        end else if (pick < 75) begin
            send_item(pick[0] ? FUNC_EXEC : FUNC_READ, 3'($urandom_range(7)),
                      5'($urandom), 8'($urandom));
        end else begin
            send_item(t_func'($urandom_range(3)), 3'($urandom_range(7)),
                      5'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        int unsigned target;
        logic [7:0]  magic;

        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_valid = 1'b0;
        i_func = FUNC_LOAD;
        i_slot = '0;
        i_byte_index = '0;
        i_write_data = '0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_cycles = 0;
        items_sent = 0;
        cur_magic = ZERO_BYTE;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int ph = 0; ph < PHASES; ph++) begin
            tx_idle_pct = (ph < 2) ? 13 : (ph < 4) ? 85 : 0;
            rx_idle_pct = (ph < 2) ? 85 : (ph < 4) ? 13 : 0;
            magic = (ph == PHASES - 1) ? 8'($urandom) : magic_plan[ph];
            apply_setting(mask_plan[ph], magic);
            if (ph == 0) begin
                run_directed();
                stall_output();
            end
            target = items_sent + ITEMS_PER_PHASE;
            while (items_sent < target) begin
                random_step();
            end
        end

        pause_until_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("register_write_program_engine test passed");
        end else begin
            $display("register_write_program_engine test failed");
        end
        $finish;
    end

endmodule
